// ===== hw/rtl/c39_pkg.sv =====
// shared types, constants and the character table of the code 39 bar pattern generator
package c39_pkg;

  localparam int MW_W     = 6;
  localparam int QZ_W     = 5;
  localparam int PIX_W    = 8;
  localparam int POS_W    = 16;
  localparam int PAT_W    = 9;
  localparam int ELEM_W   = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 6;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULE_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUIET_ZONE   = 1'b1;

  localparam logic [MW_W-1:0] MW_RESET = 6'd1;
  localparam logic [QZ_W-1:0] QZ_RESET = 5'd10;

  localparam logic [PAT_W-1:0]  GUARD_CODE = 9'h094;
  localparam logic [ELEM_W-1:0] ELEM_LAST  = 4'd9;
  localparam logic [ELEM_W-1:0] ELEM_TOP   = 4'd8;

  // pending patterns of one item, served lowest bit first
  typedef struct packed {
    logic stop;
    logic chr;
    logic start;
  } pend_t;

  typedef struct packed {
    logic restart;
    logic step;
    logic wide;
  } pos_ctl_t;

  // nine wide/narrow flags, most significant first; zero for no table entry
  function automatic logic [PAT_W-1:0] c39_lookup(input logic [7:0] code);
    logic [7:0] c;
    logic [PAT_W-1:0] p;
    c = (code >= 8'h61 && code <= 8'h7A) ? code - 8'd32 : code;
    unique case (c)
      8'h30: p = 9'h034;  8'h31: p = 9'h121;  8'h32: p = 9'h061;  8'h33: p = 9'h160;
      8'h34: p = 9'h031;  8'h35: p = 9'h130;  8'h36: p = 9'h070;  8'h37: p = 9'h025;
      8'h38: p = 9'h124;  8'h39: p = 9'h064;
      8'h41: p = 9'h109;  8'h42: p = 9'h049;  8'h43: p = 9'h148;  8'h44: p = 9'h019;
      8'h45: p = 9'h118;  8'h46: p = 9'h058;  8'h47: p = 9'h00D;  8'h48: p = 9'h10C;
      8'h49: p = 9'h04C;  8'h4A: p = 9'h01C;  8'h4B: p = 9'h103;  8'h4C: p = 9'h043;
      8'h4D: p = 9'h142;  8'h4E: p = 9'h013;  8'h4F: p = 9'h112;  8'h50: p = 9'h052;
      8'h51: p = 9'h007;  8'h52: p = 9'h106;  8'h53: p = 9'h046;  8'h54: p = 9'h016;
      8'h55: p = 9'h181;  8'h56: p = 9'h0C1;  8'h57: p = 9'h1C0;  8'h58: p = 9'h091;
      8'h59: p = 9'h190;  8'h5A: p = 9'h0D0;
      8'h2D: p = 9'h085;  8'h2E: p = 9'h184;  8'h20: p = 9'h0C4;  8'h24: p = 9'h0A8;
      8'h2F: p = 9'h0A2;  8'h2B: p = 9'h08A;  8'h25: p = 9'h02A;  8'h2A: p = GUARD_CODE;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

// ===== hw/rtl/c39_pos_unit.sv =====
// element width and saturating running start position
module c39_pos_unit
  import c39_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  pos_ctl_t         ctl,
  input  logic [MW_W-1:0]  module_width,
  input  logic [QZ_W-1:0]  quiet_zone_modules,
  output logic [PIX_W-1:0] width_pixels,
  output logic [POS_W-1:0] position
);

  logic [MW_W-1:0]      mw_eff;
  logic [MW_W+QZ_W-1:0] quiet_px;
  logic [POS_W:0]       sum;
  logic [POS_W-1:0]     pos_r;
  logic [POS_W-1:0]     pos_nxt;

  // a module width of zero counts as one
  assign mw_eff   = (module_width == '0) ? MW_W'(1) : module_width;
  assign quiet_px = (MW_W+QZ_W)'(quiet_zone_modules) * (MW_W+QZ_W)'(mw_eff);

  always_comb begin
    width_pixels = ctl.wide ? PIX_W'(mw_eff) * PIX_W'(3) : PIX_W'(mw_eff);
    sum          = {1'b0, pos_r} + (POS_W+1)'(width_pixels);
    priority if (ctl.restart) begin
      pos_nxt = POS_W'(quiet_px);
    end else if (ctl.step) begin
      pos_nxt = sum[POS_W] ? '1 : sum[POS_W-1:0];
    end else begin
      pos_nxt = pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  assign position = pos_r;

endmodule

// ===== hw/rtl/code39_bar_pattern_generator_core.sv =====
// Code 39 bar pattern generator: one message character in, one beat per bar or space out.
// Each accepted character beat expands into ten elements per pattern (start guard when
// in_tuser is set, the character when it is in the table, stop guard when in_tlast is
// set), so an item yields one, two or three patterns, or is dropped when it yields
// nothing. The element sequencer emits one element per cycle into the output register
// while the output is not stalled; the next character is taken in the cycle its
// predecessor's last element is issued, so characters stream back to back.
// Lower case is folded to upper case, a module width of zero counts as one and the
// start position saturates at 65535.
module code39_bar_pattern_generator_core
  import c39_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] char_code
  input  logic                  in_tuser,   // [0] first_of_message
  input  logic                  in_tlast,   // last_of_message
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [0] is_bar, [1] is_wide, [9:2] width_pixels,
                                            // [25:10] start_position, [31:26] zero
  output logic                  out_tlast,  // last_of_run
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_wdata
);

  logic [MW_W-1:0]   mw_r;
  logic [QZ_W-1:0]   qz_r;
  logic              act_r;
  logic              act_nxt;
  pend_t             pend_r;
  pend_t             pend_nxt;
  pend_t             pend_load;
  pend_t             pend_left;
  logic [PAT_W-1:0]  pat_r;
  logic [PAT_W-1:0]  pat_nxt;
  logic [PAT_W-1:0]  pat_load;
  logic [PAT_W-1:0]  cur_pat;
  logic [ELEM_W-1:0] elem_r;
  logic [ELEM_W-1:0] elem_nxt;
  logic [ELEM_W-1:0] bit_idx;
  logic              advance;
  logic              pat_done;
  logic              run_done;
  logic              load;
  logic              wide;
  pos_ctl_t          pos_ctl;
  logic [PIX_W-1:0]  width_px;
  logic [POS_W-1:0]  position;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              ob_bar_r;
  logic              ob_wide_r;
  logic [PIX_W-1:0]  ob_width_r;
  logic [POS_W-1:0]  ob_pos_r;
  logic              ob_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mw_r <= MW_RESET;
      qz_r <= QZ_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODULE_WIDTH: mw_r <= cfg_wdata[MW_W-1:0];
        CFG_QUIET_ZONE:   qz_r <= cfg_wdata[QZ_W-1:0];
        default:          ;
      endcase
    end
  end

  // element sequencer
  always_comb begin
    cur_pat  = (!pend_r.start && pend_r.chr) ? pat_r : GUARD_CODE;
    bit_idx  = ELEM_TOP - elem_r;
    pat_done = (elem_r == ELEM_LAST);
    wide     = !pat_done && cur_pat[bit_idx];
    // drop the pattern being served
    pend_left = pend_t'(pend_r & (pend_r - 3'd1));
    run_done  = pat_done && (pend_left == '0);
    advance   = act_r && (!out_valid_r || out_tready);
    in_tready = !act_r || (advance && run_done);
    load      = in_tvalid && in_tready;

    pat_load  = c39_lookup(in_tdata[7:0]);
    pend_load = '{stop: in_tlast, chr: (pat_load != '0), start: in_tuser};

    act_nxt  = act_r;
    pend_nxt = pend_r;
    pat_nxt  = pat_r;
    elem_nxt = elem_r;
    if (advance) begin
      if (pat_done) begin
        elem_nxt = '0;
        pend_nxt = pend_left;
        act_nxt  = !run_done;
      end else begin
        elem_nxt = elem_r + ELEM_W'(1);
      end
    end
    if (load) begin
      act_nxt  = (pend_load != '0);
      pend_nxt = pend_load;
      pat_nxt  = pat_load;
      elem_nxt = '0;
    end

    pos_ctl = '{restart: load && in_tuser, step: advance, wide: wide};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      pend_r <= '0;
      elem_r <= '0;
    end else begin
      act_r  <= act_nxt;
      pend_r <= pend_nxt;
      elem_r <= elem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pat_r <= pat_nxt;
  end

  c39_pos_unit u_pos (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (pos_ctl),
    .module_width       (mw_r),
    .quiet_zone_modules (qz_r),
    .width_pixels       (width_px),
    .position           (position)
  );

  // output register
  assign out_valid_nxt = advance || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ob_bar_r   <= !elem_r[0];
      ob_wide_r  <= wide;
      ob_width_r <= width_px;
      ob_pos_r   <= position;
      ob_last_r  <= run_done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, ob_pos_r, ob_width_r, ob_wide_r, ob_bar_r};
  assign out_tlast  = ob_last_r;

endmodule

// ===== hw/rtl/c39_port_checker.sv =====
// port-level checks of the code 39 bar pattern generator, bound to the top level
module c39_port_checker
  import c39_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output beat valid straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output beat changed");

  a_width_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[9:2] != 8'd0)
    else $error("element of zero width");

  // every run ends on the narrow inter-character gap
  a_run_ends_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[1:0] == 2'b00)
    else $error("run does not end on a narrow space");

endmodule

bind code39_bar_pattern_generator_core c39_port_checker u_port_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
